// File: sv/gtl_pkg.sv
// Package with the constants, state codes and control structs of the gamma table block.
package gtl_pkg;

  localparam int unsigned LOG_DEPTH = 511;
  localparam int unsigned ADDR_W = $clog2(LOG_DEPTH);

  localparam logic [ADDR_W-1:0] LOG_FIRST = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] LOG_LAST = ADDR_W'(LOG_DEPTH - 1);
  localparam logic [ADDR_W-1:0] LOG_NO_ADDR = ADDR_W'(LOG_DEPTH);

  localparam logic [15:0] GUARD_LIMIT = 16'h3f80;
  localparam logic [15:0] GAMMA_RESET = 16'd16384;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_GAMMA = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SUM,
    ST_WALK,
    ST_DONE
  } gtl_state_t;

  typedef struct packed {
    logic take_write;
    logic take_entry;
    logic mult;
    logic sum;
    logic walk_step;
    logic load_result;
  } gtl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_op;
    logic in_zero;
    logic guard_next;
    logic walk_more;
    logic out_free;
  } gtl_status_t;

endpackage

// File: sv/gtl_channels.sv
// Valid/ready channel interfaces for the request and result beats.
interface gtl_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [8:0]  log_index;
  logic [15:0] log_value;
  logic [7:0]  entry_index;

  modport source (output valid, op, log_index, log_value, entry_index, input ready);
  modport sink (input valid, op, log_index, log_value, entry_index, output ready);
endinterface

interface gtl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] entry_index_out;
  logic [7:0] entry_value;
  logic       guard_hit;

  modport source (output valid, entry_index_out, entry_value, guard_hit, input ready);
  modport sink (input valid, entry_index_out, entry_value, guard_hit, output ready);
endinterface

// File: sv/gamma_table_from_log_16bit.sv
// Top level of the gamma table generator: channels, configuration register and wiring.
//
//   channel   dir   handshake          payload
//   in_ch     in    valid / ready      op, log_index, log_value, entry_index
//   out_ch    out   valid / ready      entry_index_out, entry_value, guard_hit
//   cfg       in    cfg_we (no stall)  cfg_wdata -> gamma exponent
//
// A write beat (op 0) gives no result. A gamma beat (op 1) for entry zero goes straight
// to the result; otherwise it forms the products, then the sum, then walks the pointer,
// where every step is one read of the single-port log table memory; a guard trip skips
// the walk. Rising entry indexes keep the pointer, so a rising sweep walks on from it.
// Reset is synchronous: pointer to 1, previous entry to 0, exponent to 16384; the table
// contents are not cleared. The block takes no new beat while a gamma beat is in work,
// and holds a finished result in its output register until out_ch.ready takes it.
module gamma_table_from_log_16bit
  import gtl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  gtl_in_if.sink      in_ch,
  gtl_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  gtl_cmd_t    cmd;
  gtl_status_t st;
  logic        in_ready;

  assign in_ch.ready = in_ready;

  // The controller sees only status from the datapath and issues at most one command a cycle.
  gtl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // The datapath owns the table, the arithmetic, the walk pointer and the output beat.
  gtl_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_ch.valid),
    .op              (in_ch.op),
    .log_index       (in_ch.log_index),
    .log_value       (in_ch.log_value),
    .entry_index     (in_ch.entry_index),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .entry_index_out (out_ch.entry_index_out),
    .entry_value     (out_ch.entry_value),
    .guard_hit       (out_ch.guard_hit)
  );

endmodule

// File: sv/gtl_ctrl.sv
// Controller state machine that sequences table writes, products, sum and pointer walk.
module gtl_ctrl
  import gtl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  gtl_status_t st,
  output logic        in_ready,
  output gtl_cmd_t    cmd
);

  gtl_state_t state;
  gtl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (st.in_valid) begin
          if (st.in_op == OP_GAMMA) begin
            cmd.take_entry = 1'b1;
            state_next = st.in_zero ? ST_DONE : ST_PROD;
          end else begin
            cmd.take_write = 1'b1;
          end
        end
      end
      ST_PROD: begin
        cmd.mult = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        state_next = st.guard_next ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        if (st.walk_more) begin
          cmd.walk_step = 1'b1;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.load_result = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Only one datapath action is ever requested in a cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("gtl_ctrl: more than one command at once");

  // A request is only taken while nothing else is in flight.
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_entry || cmd.take_write) |-> (state == ST_IDLE && st.in_valid))
    else $error("gtl_ctrl: request taken outside idle");

  // After a guard trip the walk is skipped and the result goes out directly.
  a_guard_skip: assert property (@(posedge clk) disable iff (rst)
    (cmd.sum && st.guard_next) |=> (state == ST_DONE))
    else $error("gtl_ctrl: guard did not skip the walk");

endmodule

// File: sv/gtl_datapath.sv
// Datapath with the log table memory, split products, pointer walk and result register.
module gtl_datapath
  import gtl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              op,
  input  logic [ADDR_W-1:0] log_index,
  input  logic [15:0]       log_value,
  input  logic [7:0]        entry_index,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  gtl_cmd_t          cmd,
  output gtl_status_t       st,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        entry_index_out,
  output logic [7:0]        entry_value,
  output logic              guard_hit
);

  logic [15:0]       log_mem [0:LOG_DEPTH-1];
  logic [15:0]       rdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic [15:0]       gamma;
  logic [ADDR_W-1:0] ptr;
  logic [7:0]        prev;
  logic [7:0]        entry;
  logic              zero;
  logic              guard;
  logic [15:0]       hi;
  logic [15:0]       mid_a;
  logic [15:0]       mid_b;
  logic [16:0]       y;
  logic [16:0]       y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= GAMMA_RESET;
    end else if (cfg_we) begin
      gamma <= cfg_wdata;
    end
  end

  // Table writes to the address one past the end are dropped.
  always_ff @(posedge clk) begin
    if (cmd.take_write && log_index != LOG_NO_ADDR) begin
      log_mem[log_index] <= log_value;
    end
  end

  always_comb begin
    rd_en = 1'b1;
    rd_addr = ptr;
    if (cmd.take_entry) begin
      rd_addr = {entry_index, 1'b0};
    end else if (cmd.walk_step) begin
      rd_addr = ptr + LOG_FIRST;
    end else if (!cmd.mult) begin
      rd_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= log_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= LOG_FIRST;
      prev <= '0;
    end else if (cmd.take_entry) begin
      if (entry_index <= prev) begin
        ptr <= LOG_FIRST;
      end
      prev <= entry_index;
    end else if (cmd.walk_step) begin
      ptr <= ptr + LOG_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_entry) begin
      entry <= entry_index;
      zero <= (entry_index == 8'd0);
      guard <= 1'b0;
    end
    if (cmd.mult) begin
      hi <= rdata[15:8] * gamma[15:8];
      mid_a <= rdata[15:8] * gamma[7:0];
      mid_b <= rdata[7:0] * gamma[15:8];
    end
    if (cmd.sum) begin
      guard <= st.guard_next;
      y <= y_next;
    end
  end

  assign y_next = {hi[14:0], 2'b00} + 17'(mid_a[15:6]) + 17'(mid_b[15:6]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      entry_index_out <= entry;
      guard_hit <= guard;
      entry_value <= (guard || zero) ? 8'd0 : ptr[ADDR_W-1:1];
    end
  end

  always_comb begin
    st.in_valid = in_valid;
    st.in_op = op;
    st.in_zero = (entry_index == 8'd0);
    st.guard_next = (hi > GUARD_LIMIT);
    st.walk_more = (ptr < LOG_LAST) && (17'(rdata) > y);
    st.out_free = !out_valid || out_ready;
  end

  // The walk pointer never leaves the readable part of the table.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (ptr >= LOG_FIRST) && (ptr <= LOG_LAST))
    else $error("gtl_datapath: walk pointer out of range");

  // A new result never overwrites a beat that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> (!out_valid || out_ready))
    else $error("gtl_datapath: result overwritten");

  // A guard trip always reports a zero value.
  a_guard_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && guard_hit) |-> (entry_value == 8'd0))
    else $error("gtl_datapath: guard result not zero");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the gamma table generator, with its own predictor and scoreboard.
`timescale 1ns / 1ps

// The log table is loaded in full before any gamma request, so the block
// never reads a word that was never written. The predictor then follows every
// accepted input beat. Write beats update its copy of the log table. Gamma
// beats compute the expected entry and queue it. A checker process compares
// each result beat with the oldest queued entry, field by field.
module testbench;
  import gtl_pkg::*;

  // No beat may be accepted on either channel for this many cycles in a row.
  // The longest correct wait is a full pointer walk plus a long receiver
  // stall, or the deliberate hold-off, so this leaves a wide margin.
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned ITEMS_PER_SETTING = 160;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] entry_index;
    logic [7:0] entry_value;
    logic       guard_hit;
  } gamma_entry_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  gtl_in_if  in_ch ();
  gtl_out_if out_ch ();

  gamma_table_from_log_16bit uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: a private copy of the log table, the walk pointer, the
  // last requested entry and the gamma exponent register.
  logic [15:0]  log_words [0:LOG_DEPTH-1];
  logic [8:0]   walk_pos;
  logic [7:0]   last_entry;
  logic [15:0]  gamma_exp;
  gamma_entry_t pending_entries [$];

  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Expected result of one gamma request. It updates the pointer state as the
  // block does: a request that does not rise above the last one restarts the
  // walk at 1, and a guard trip leaves the pointer where it is.
  function automatic gamma_entry_t predict_gamma_entry(input logic [7:0] entry);
    gamma_entry_t res;
    int unsigned  x, xhi, xlo, ghi, glo, high, y, pos;
    res.entry_index = entry;
    res.entry_value = 8'd0;
    res.guard_hit   = 1'b0;
    if (entry <= last_entry) begin
      walk_pos = LOG_FIRST;
    end
    last_entry = entry;
    // Entry zero is fixed at zero and does not depend on the table.
    if (entry == 8'd0) begin
      return res;
    end
    x    = log_words[{entry, 1'b0}];
    xhi  = x >> 8;
    xlo  = x & 32'hff;
    ghi  = gamma_exp >> 8;
    glo  = gamma_exp & 16'hff;
    high = xhi * ghi;
    if (high > GUARD_LIMIT) begin
      res.guard_hit = 1'b1;
      return res;
    end
    // The scaled value keeps its 17th bit; it is not wrapped at 16 bits.
    y   = ((high << 2) + ((xhi * glo) >> 6) + ((xlo * ghi) >> 6)) & 32'h1ffff;
    pos = walk_pos;
    if (pos == 0 || pos > LOG_LAST) begin
      pos = LOG_FIRST;
    end
    // The walk stops at the last table word even if it is still above y.
    while (pos < LOG_LAST && log_words[pos] > y) begin
      pos++;
    end
    walk_pos = 9'(pos);
    res.entry_value = 8'(pos >> 1);
    return res;
  endfunction

  // One input beat. Idle gaps come before the beat, one random draw per cycle.
  // Valid stays high after the beat is taken; the next call either replaces
  // the payload or drops valid at the next falling edge.
  task automatic send_item(input logic op, input logic [8:0] addr,
                           input logic [15:0] value, input logic [7:0] entry);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.log_index   <= addr;
    in_ch.log_value   <= value;
    in_ch.entry_index <= entry;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    if (op == OP_WRITE) begin
      // Address 511 lies past the table and the block drops the write.
      if (addr < LOG_DEPTH) begin
        log_words[addr] = value;
      end
    end else begin
      pending_entries.push_back(predict_gamma_entry(entry));
    end
  endtask

  // The unused fields of each beat carry random values so that their bits move too.
  task automatic send_write(input logic [8:0] addr, input logic [15:0] value);
    send_item(OP_WRITE, addr, value, 8'($urandom));
  endtask

  task automatic send_entry(input logic [7:0] entry);
    send_item(OP_GAMMA, 9'($urandom), 16'($urandom), entry);
  endtask

  // A write that keeps the table falling: the new word lies between its neighbors.
  task automatic send_smooth_write();
    int unsigned idx;
    idx = $urandom_range(LOG_LAST - 1, 1);
    send_write(9'(idx), 16'($urandom_range(log_words[idx - 1], log_words[idx + 1])));
  endtask

  // Fill the whole table with a falling curve from top down to about 1, the
  // shape of a scaled negative logarithm.
  task automatic load_log_table(input logic [15:0] top);
    int val;
    val = top;
    for (int j = 0; j < LOG_DEPTH; j++) begin
      send_write(9'(j), 16'(val));
      val -= $urandom_range(2 * top / 510 + 1);
      if (val < 1) begin
        val = 1;
      end
    end
  endtask

  // The sender stops until every expected result has come back, then keeps
  // waiting so that a trailing write beat has left the block too.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_entries.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // The exponent register is only written while the block is idle.
  task automatic set_gamma(input logic [15:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    gamma_exp = value;
  endtask

  // Writes at both ends of the address range, including the one past the end.
  task automatic test_table_edges();
    send_write(9'd511, 16'hffff);
    send_write(9'd0, 16'hffff);
    send_write(LOG_LAST, 16'h0000);
    send_entry(8'd255);
  endtask

  task automatic test_entry_zero();
    send_entry(8'd0);
    send_entry(8'd1);
    send_entry(8'd0);
  endtask

  // Rising requests keep the pointer; equal and falling ones restart it.
  task automatic test_pointer_restart();
    send_entry(8'd1);
    send_entry(8'd2);
    send_entry(8'd200);
    send_entry(8'd255);
    send_entry(8'd255);
    send_entry(8'd100);
    send_entry(8'd101);
  endtask

  // The largest exponent pushes the high product of the first entries past
  // the guard limit; the last entry reads a zero word and stays below it.
  task automatic test_guard();
    set_gamma(16'hffff);
    send_entry(8'd1);
    send_entry(8'd2);
    send_entry(8'd255);
  endtask

  // With a zero exponent every scaled value is zero, so the walk runs until it
  // stops at the last table word.
  task automatic test_walk_end();
    set_gamma(16'h0000);
    send_entry(8'd1);
    send_entry(8'd255);
    send_entry(8'd3);
    set_gamma(GAMMA_RESET);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // a rising sweep, so the output register fills and the input stalls.
  task automatic test_backpressure();
    wait_drained();
    hold_off_left = HOLD_OFF_CYCLES;
    for (int e = 1; e < 256; e += 15) begin
      send_entry(8'(e));
    end
    wait_drained();
  endtask

  // Mostly rising sweeps over the gamma entries with random start and stride,
  // a few smooth table updates among them, and random requests and random
  // writes as noise. Each call runs three exponent settings.
  task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct,
                                     input logic [15:0] g0, input logic [15:0] g1,
                                     input logic [15:0] g2);
    logic [15:0] gammas [3];
    int          left;
    int          entry;
    int          step;
    int unsigned pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    gammas = '{g0, g1, g2};
    foreach (gammas[k]) begin
      set_gamma(gammas[k]);
      left = ITEMS_PER_SETTING;
      while (left > 0) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          entry = $urandom_range(40);
          case ($urandom_range(3))
            0: begin
              step = 1;
            end
            1: begin
              step = 2;
            end
            2: begin
              step = $urandom_range(8, 3);
            end
            default: begin
              step = $urandom_range(40, 9);
            end
          endcase
          while (entry <= 255 && left > 0) begin
            if ($urandom_range(99) < 4) begin
              send_smooth_write();
            end
            send_entry(8'(entry));
            left--;
            entry += step;
          end
        end else if (pick < 85) begin
          send_entry(8'($urandom_range(255)));
          left--;
        end else if (pick < 93) begin
          send_smooth_write();
          left--;
        end else begin
          send_write(9'($urandom_range(511)), 16'($urandom));
          left--;
        end
      end
    end
  endtask

  // Receiver: random stalls at the chosen rate, or a counted hold-off.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Scoreboard: every result beat is matched against the oldest expectation.
  always @(posedge clk) begin
    gamma_entry_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected result beat: index %0d value %0d guard %0b",
                   out_ch.entry_index_out, out_ch.entry_value, out_ch.guard_hit);
        end
      end else begin
        want = pending_entries.pop_front();
        if (out_ch.entry_index_out !== want.entry_index
            || out_ch.entry_value !== want.entry_value
            || out_ch.guard_hit !== want.guard_hit) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch: expected index %0d value %0d guard %0b, got %0d %0d %0b",
                     want.entry_index, want.entry_value, want.guard_hit,
                     out_ch.entry_index_out, out_ch.entry_value, out_ch.guard_hit);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = 16'h0000;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_WRITE;
    in_ch.log_index   = 9'd0;
    in_ch.log_value   = 16'h0000;
    in_ch.entry_index = 8'd0;
    out_ch.ready      = 1'b0;
    mismatches        = 0;
    idle_cycles       = 0;
    hold_off_left     = 0;
    send_idle_pct     = 21;
    recv_idle_pct     = 54;
    walk_pos          = LOG_FIRST;
    last_entry        = 8'd0;
    gamma_exp         = GAMMA_RESET;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed part, with the sender idling less than the receiver.
    load_log_table(16'hffff);
    test_table_edges();
    test_entry_zero();
    test_pointer_restart();
    test_guard();
    test_walk_end();
    test_backpressure();

    // Random part: receiver-heavy idling, sender-heavy idling, then none.
    test_random_traffic(21, 54, GAMMA_RESET, 16'hffff, 16'($urandom));
    test_random_traffic(54, 21, 16'h0000, 16'($urandom_range(30000, 8000)),
                        16'($urandom));
    test_random_traffic(0, 0, 16'($urandom), 16'h0001, GAMMA_RESET);

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_entries.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
